// File: hdl/fuc_pkg.sv
// Shared types and constants for the FDTD update coefficient block.
`timescale 1ns / 1ps
`default_nettype none
package fuc_pkg;

  // Lanes: Ezx, Ezy, Hx, Hy
  localparam int NLANE     = 4;
  localparam int LANE_EZX  = 0;
  localparam int LANE_EZY  = 1;
  localparam int LANE_HX   = 2;
  localparam int LANE_HY   = 3;
  // Magnetic lanes average material over the half cell
  localparam logic [NLANE-1:0] LANE_MAG = 4'b1100;

  // Fixed datapath widths
  localparam int OPND_W    = 33;   // eps sum or sigma sum
  localparam int PROD_W    = 65;   // 33 x 32 product
  localparam int DIFF_W    = 65;   // |p - q|
  localparam int D_W       = 66;   // p + q
  localparam int DW_W      = 98;   // d * width
  localparam int DEN_W     = 130;  // d * width * mu
  localparam int SPLIT     = 33;   // operand slice for the multipliers
  localparam int DEC_FRAC  = 30;   // decay fraction bits
  localparam int GAIN_FRAC = 16;   // gain fraction bits
  localparam int QUO_BITS  = 32;

  localparam int FRONT_LAT = 8;
  localparam int DIV_LAT   = QUO_BITS + 1;

  localparam logic [31:0] DECAY_ONE = 32'h4000_0000;
  localparam logic [31:0] GAIN_SAT  = 32'hFFFF_FFFF;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_TIME_STEP = 2'd0,
    REG_WIDTH_X   = 2'd1,
    REG_WIDTH_Y   = 2'd2,
    REG_PERM      = 2'd3
  } cfg_reg_t;

  // Values carried per lane from the front to the dividers
  typedef struct packed {
    logic [DIFF_W-1:0] diff;   // |p - q|
    logic [D_W-1:0]    d;      // loss denominator
    logic              sign;   // decay is negative
    logic              zd;     // loss denominator is zero
    logic [PROD_W-1:0] gn;     // gain numerator before scaling
    logic              zg;     // width or permeability is zero
  } lane_carry_t;

  typedef struct packed {
    lane_carry_t      carry;
    logic [DEN_W-1:0] den;     // gain denominator
  } lane_job_t;

  typedef struct packed {
    lane_job_t [NLANE-1:0] lane;
  } job_t;

  typedef struct packed {
    logic sign;
    logic zd;
    logic zg;
  } side_t;

  typedef struct packed {
    logic [NLANE-1:0][31:0] decay;
    logic [NLANE-1:0][31:0] gain;
    logic                   fault;
  } result_t;

endpackage
`default_nettype wire

// File: hdl/fdtd_update_coefficients_top.sv
// Top level: configuration registers, front and back sections, queues.
//
//  Channel  Ports                         Transfer when
//  input    in_push/in_full, 7 fields     in_push & !in_full
//  result   out_pop/out_empty, 9 fields   out_pop & !out_empty
//  config   cfg_wr_en, cfg_index, data    cfg_wr_en
//
// One cell is taken per cycle while the front section is not stalled. The
// path runs through 8 front stages, the middle queue, 33 divider stages (an
// overflow check, then one quotient bit per stage) and the output queue. Reset
// is synchronous, active low, and empties both queues and all pipelines. Each
// section stalls only when its last stage holds an item whose queue is full.
`timescale 1ns / 1ps
`default_nettype none
module fdtd_update_coefficients_top #(
  parameter int FRAC_BITS   = 24,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [31:0]        in_eps_here,
  input  logic [31:0]        in_eps_next_x,
  input  logic [31:0]        in_eps_next_y,
  input  logic [31:0]        in_sigx_here,
  input  logic [31:0]        in_sigx_next_x,
  input  logic [31:0]        in_sigy_here,
  input  logic [31:0]        in_sigy_next_y,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [31:0] out_ezx_decay,
  output logic [31:0]        out_ezx_gain,
  output logic signed [31:0] out_ezy_decay,
  output logic [31:0]        out_ezy_gain,
  output logic signed [31:0] out_hx_decay,
  output logic [31:0]        out_hx_gain,
  output logic signed [31:0] out_hy_decay,
  output logic [31:0]        out_hy_gain,
  output logic               out_divide_fault,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wr_data
);
  import fuc_pkg::*;

  localparam logic [31:0] ONE_RST  = 32'(1) << FRAC_BITS;
  localparam logic [31:0] HALF_RST = 32'(1) << (FRAC_BITS - 1);

  logic [31:0] time_step_r, width_x_r, width_y_r, perm_r;
  job_t        fr_job, mid_job;
  logic        fr_valid, mid_full, mid_empty, bk_pop;
  result_t     bk_res, out_res;
  logic        bk_push, out_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r <= HALF_RST;
      width_x_r   <= ONE_RST;
      width_y_r   <= ONE_RST;
      perm_r      <= ONE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_TIME_STEP: time_step_r <= cfg_wr_data;
        REG_WIDTH_X:   width_x_r   <= cfg_wr_data;
        REG_WIDTH_Y:   width_y_r   <= cfg_wr_data;
        REG_PERM:      perm_r      <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  fuc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .eps_here     (in_eps_here),
    .eps_next_x   (in_eps_next_x),
    .eps_next_y   (in_eps_next_y),
    .sigx_here    (in_sigx_here),
    .sigx_next_x  (in_sigx_next_x),
    .sigy_here    (in_sigy_here),
    .sigy_next_y  (in_sigy_next_y),
    .time_step    (time_step_r),
    .cell_width_x (width_x_r),
    .cell_width_y (width_y_r),
    .permeability (perm_r),
    .job          (fr_job),
    .job_valid    (fr_valid),
    .job_full     (mid_full)
  );

  // queue between front and back
  fuc_fifo #(.W($bits(job_t)), .DEPTH(QUEUE_DEPTH)) u_midq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fr_valid),
    .wdata (fr_job),
    .full  (mid_full),
    .pop   (bk_pop),
    .rdata (mid_job),
    .empty (mid_empty)
  );

  fuc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (mid_job),
    .job_valid (!mid_empty),
    .job_pop   (bk_pop),
    .res       (bk_res),
    .res_push  (bk_push),
    .res_full  (out_full)
  );

  // result queue
  fuc_fifo #(.W($bits(result_t)), .DEPTH(QUEUE_DEPTH)) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (bk_push),
    .wdata (bk_res),
    .full  (out_full),
    .pop   (out_pop),
    .rdata (out_res),
    .empty (out_empty)
  );

  assign out_ezx_decay    = $signed(out_res.decay[LANE_EZX]);
  assign out_ezy_decay    = $signed(out_res.decay[LANE_EZY]);
  assign out_hx_decay     = $signed(out_res.decay[LANE_HX]);
  assign out_hy_decay     = $signed(out_res.decay[LANE_HY]);
  assign out_ezx_gain     = out_res.gain[LANE_EZX];
  assign out_ezy_gain     = out_res.gain[LANE_EZY];
  assign out_hx_gain      = out_res.gain[LANE_HX];
  assign out_hy_gain      = out_res.gain[LANE_HY];
  assign out_divide_fault = out_res.fault;

  // a front item blocked by the middle queue stays put
  a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (fr_valid && mid_full) |=> (fr_valid && $stable(fr_job)))
    else $error("front item lost while middle queue full");

  // the back never offers a result the output queue cannot take
  a_back_push: assert property (@(posedge clk) disable iff (!rst_n)
    !(bk_push && out_full))
    else $error("result pushed into full output queue");

  // the back only draws from a non-empty middle queue
  a_back_pop: assert property (@(posedge clk) disable iff (!rst_n)
    bk_pop |-> !mid_empty)
    else $error("back popped an empty middle queue");

  // a time step write lands in its register
  a_cfg_dt: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr_en && cfg_index == REG_TIME_STEP) |=> (time_step_r == $past(cfg_wr_data)))
    else $error("time step write not taken");
endmodule
`default_nettype wire

// File: hdl/fuc_fifo.sv
// Small register queue used between the pipeline sections and at the output.
`timescale 1ns / 1ps
`default_nettype none
module fuc_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);
  localparam int AW = $clog2(DEPTH);

  logic [W-1:0] mem_r [DEPTH];
  logic [AW-1:0] wr_r, rd_r;
  logic [AW:0]   cnt_r;
  logic          push_ok, pop_ok;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = mem_r[rd_r];

  // storage
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_r] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push_ok) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop_ok) begin
        rd_r <= rd_r + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop_ok && !push_ok) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// File: hdl/fuc_div.sv
// Pipelined restoring divider, one quotient bit per stage, 32-bit saturating quotient.
`timescale 1ns / 1ps
`default_nettype none
module fuc_div #(
  parameter int NW = 95,
  parameter int DW = 66
) (
  input  logic          clk,
  input  logic          ce,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [31:0]   quo
);
  import fuc_pkg::*;

  localparam int CW = (NW > DW + QUO_BITS) ? NW : DW + QUO_BITS;

  logic [NW-1:0]       rem_r [QUO_BITS];
  logic [DW-1:0]       den_r [QUO_BITS];
  logic [QUO_BITS-1:0] q_r   [1:QUO_BITS];
  logic                sat_r [QUO_BITS+1];

  // first stage: overflow check against den * 2^32
  always_ff @(posedge clk) begin
    if (ce) begin
      rem_r[0] <= num;
      den_r[0] <= den;
      sat_r[0] <= (CW'(num) >= (CW'(den) << QUO_BITS));
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 1; k <= QUO_BITS; k++) begin : g_stage
    localparam int BIT = QUO_BITS - k;
    logic [CW-1:0]       trial;
    logic                take;
    logic [QUO_BITS-1:0] q_prev, q_nxt;

    assign trial = CW'(den_r[k-1]) << BIT;
    assign take  = (CW'(rem_r[k-1]) >= trial);
    if (k == 1) begin : g_first
      assign q_prev = '0;
    end else begin : g_rest
      assign q_prev = q_r[k-1];
    end

    always_comb begin
      q_nxt      = q_prev;
      q_nxt[BIT] = take;
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        q_r[k]   <= q_nxt;
        sat_r[k] <= sat_r[k-1];
      end
    end

    if (k < QUO_BITS) begin : g_keep
      always_ff @(posedge clk) begin
        if (ce) begin
          rem_r[k] <= take ? NW'(CW'(rem_r[k-1]) - trial) : rem_r[k-1];
          den_r[k] <= den_r[k-1];
        end
      end
    end
  end

  assign quo = sat_r[QUO_BITS] ? GAIN_SAT : q_r[QUO_BITS];
endmodule
`default_nettype wire

// File: hdl/fuc_front.sv
// Front section: takes cells, forms the loss and gain numerators and denominators.
`timescale 1ns / 1ps
`default_nettype none
module fuc_front #(
  parameter int FRAC_BITS = 24
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  logic [31:0]   eps_here,
  input  logic [31:0]   eps_next_x,
  input  logic [31:0]   eps_next_y,
  input  logic [31:0]   sigx_here,
  input  logic [31:0]   sigx_next_x,
  input  logic [31:0]   sigy_here,
  input  logic [31:0]   sigy_next_y,
  input  logic [31:0]   time_step,
  input  logic [31:0]   cell_width_x,
  input  logic [31:0]   cell_width_y,
  input  logic [31:0]   permeability,
  output fuc_pkg::job_t job,
  output logic          job_valid,
  input  logic          job_full
);
  import fuc_pkg::*;

  logic                          ce;
  logic [FRONT_LAT-1:0]          v_r;
  logic [NLANE-1:0][OPND_W-1:0]  twoeps_c, loss_c;
  logic [NLANE-1:0][31:0]        width_c, mu_c;

  // stall the whole section only when its last item cannot leave
  assign ce        = !(v_r[FRONT_LAT-1] && job_full);
  assign in_full   = !ce;
  assign job_valid = v_r[FRONT_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (ce) begin
      v_r <= {v_r[FRONT_LAT-2:0], in_push};
    end
  end

  // per-lane material operands; electric lanes use mu of one
  always_comb begin
    twoeps_c[LANE_EZX] = {eps_here, 1'b0};
    twoeps_c[LANE_EZY] = {eps_here, 1'b0};
    twoeps_c[LANE_HX]  = OPND_W'(eps_here) + OPND_W'(eps_next_y);
    twoeps_c[LANE_HY]  = OPND_W'(eps_here) + OPND_W'(eps_next_x);
    loss_c[LANE_EZX]   = OPND_W'(sigx_here);
    loss_c[LANE_EZY]   = OPND_W'(sigy_here);
    loss_c[LANE_HX]    = OPND_W'(sigy_here) + OPND_W'(sigy_next_y);
    loss_c[LANE_HY]    = OPND_W'(sigx_here) + OPND_W'(sigx_next_x);
    width_c[LANE_EZX]  = cell_width_x;
    width_c[LANE_EZY]  = cell_width_y;
    width_c[LANE_HX]   = cell_width_y;
    width_c[LANE_HY]   = cell_width_x;
    mu_c[LANE_EZX]     = 32'd1;
    mu_c[LANE_EZY]     = 32'd1;
    mu_c[LANE_HX]      = permeability;
    mu_c[LANE_HY]      = permeability;
  end

  for (genvar l = 0; l < NLANE; l++) begin : g_lane
    localparam int H = LANE_MAG[l] ? 1 : 0;

    logic [OPND_W-1:0] te1_r, ls1_r, gs1_r, te2_r;
    logic              zg1_r, zg2_r;
    logic [PROD_W-1:0] q2_r, gn2_r;
    logic [D_W-1:0]    p_nxt, q_ext, d_nxt;
    lane_carry_t       c_r [3:FRONT_LAT];
    logic [PROD_W-1:0] pp0_r, pp1_r, m0_r, m1_r;
    logic [DW_W-1:0]   dw5_r;
    logic [63:0]       m2_r, m2b_r;
    logic [DEN_W-1:0]  s7_r, den8_r;

    // stage 3 combinational: loss denominator and decay numerator
    assign p_nxt = D_W'(te2_r) << (FRAC_BITS + H);
    assign q_ext = D_W'(q2_r);
    assign d_nxt = p_nxt + q_ext;

    always_ff @(posedge clk) begin
      if (ce) begin
        // stage 1: operands
        te1_r <= twoeps_c[l];
        ls1_r <= loss_c[l];
        gs1_r <= LANE_MAG[l] ? twoeps_c[l] : OPND_W'(2);
        zg1_r <= (width_c[l] == '0) || (mu_c[l] == '0);
        // stage 2: sigma * dt and gain numerator
        q2_r  <= PROD_W'(ls1_r) * PROD_W'(time_step);
        gn2_r <= PROD_W'(gs1_r) * PROD_W'(time_step);
        te2_r <= te1_r;
        zg2_r <= zg1_r;
        // stage 3
        c_r[3].d    <= d_nxt;
        c_r[3].diff <= (p_nxt >= q_ext) ? DIFF_W'(p_nxt - q_ext) : DIFF_W'(q_ext - p_nxt);
        c_r[3].sign <= (q_ext > p_nxt);
        c_r[3].zd   <= (d_nxt == '0);
        c_r[3].gn   <= gn2_r;
        c_r[3].zg   <= zg2_r;
        for (int k = 4; k <= FRONT_LAT; k++) begin
          c_r[k] <= c_r[k-1];
        end
        // stage 4: d * width in two slices
        pp0_r <= PROD_W'(c_r[3].d[SPLIT-1:0]) * PROD_W'(width_c[l]);
        pp1_r <= PROD_W'(c_r[3].d[D_W-1:SPLIT]) * PROD_W'(width_c[l]);
        // stage 5
        dw5_r <= DW_W'(pp0_r) + (DW_W'(pp1_r) << SPLIT);
        // stage 6: times mu in three slices
        m0_r  <= PROD_W'(dw5_r[SPLIT-1:0]) * PROD_W'(mu_c[l]);
        m1_r  <= PROD_W'(dw5_r[2*SPLIT-1:SPLIT]) * PROD_W'(mu_c[l]);
        m2_r  <= 64'(dw5_r[DW_W-1:2*SPLIT]) * 64'(mu_c[l]);
        // stages 7 and 8: sum the slices
        s7_r   <= DEN_W'(m0_r) + (DEN_W'(m1_r) << SPLIT);
        m2b_r  <= m2_r;
        den8_r <= s7_r + (DEN_W'(m2b_r) << (2 * SPLIT));
      end
    end

    assign job.lane[l].carry = c_r[FRONT_LAT];
    assign job.lane[l].den   = den8_r;
  end
endmodule
`default_nettype wire

// File: hdl/fuc_back.sv
// Back section: divider pipelines for decay and gain, special-case override.
`timescale 1ns / 1ps
`default_nettype none
module fuc_back #(
  parameter int FRAC_BITS = 24
) (
  input  logic             clk,
  input  logic             rst_n,
  input  fuc_pkg::job_t    job,
  input  logic             job_valid,
  output logic             job_pop,
  output fuc_pkg::result_t res,
  output logic             res_push,
  input  logic             res_full
);
  import fuc_pkg::*;

  localparam int DNW = DIFF_W + DEC_FRAC;
  localparam int GNW = PROD_W + 2 * FRAC_BITS + GAIN_FRAC + 1;

  logic                   ce;
  logic [DIV_LAT-1:0]     v_r;
  side_t [NLANE-1:0]      side_in;
  side_t [NLANE-1:0]      side_r [DIV_LAT];
  logic [NLANE-1:0][31:0] qd, qg;

  assign ce       = !(v_r[DIV_LAT-1] && res_full);
  assign job_pop  = ce && job_valid;
  assign res_push = v_r[DIV_LAT-1] && !res_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (ce) begin
      v_r <= {v_r[DIV_LAT-2:0], job_pop};
    end
  end

  // flags travel alongside the dividers
  always_ff @(posedge clk) begin
    if (ce) begin
      side_r[0] <= side_in;
      for (int k = 1; k < DIV_LAT; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  for (genvar l = 0; l < NLANE; l++) begin : g_lane
    localparam int H = LANE_MAG[l] ? 1 : 0;
    logic [DNW-1:0] dnum;
    logic [GNW-1:0] gnum;

    assign side_in[l].sign = job.lane[l].carry.sign;
    assign side_in[l].zd   = job.lane[l].carry.zd;
    assign side_in[l].zg   = job.lane[l].carry.zg;
    assign dnum = {job.lane[l].carry.diff, {DEC_FRAC{1'b0}}};
    assign gnum = GNW'(job.lane[l].carry.gn) << (2 * FRAC_BITS + GAIN_FRAC + H);

    fuc_div #(.NW(DNW), .DW(D_W)) u_decay (
      .clk (clk),
      .ce  (ce),
      .num (dnum),
      .den (job.lane[l].carry.d),
      .quo (qd[l])
    );

    fuc_div #(.NW(GNW), .DW(DEN_W)) u_gain (
      .clk (clk),
      .ce  (ce),
      .num (gnum),
      .den (job.lane[l].den),
      .quo (qg[l])
    );
  end

  // a zero loss denominator forces unit decay; it or a zero width or permeability saturates the gain and sets fault
  always_comb begin
    res.fault = 1'b0;
    for (int l = 0; l < NLANE; l++) begin
      if (side_r[DIV_LAT-1][l].zd) begin
        res.decay[l] = DECAY_ONE;
      end else if (side_r[DIV_LAT-1][l].sign) begin
        res.decay[l] = 32'd0 - qd[l];
      end else begin
        res.decay[l] = qd[l];
      end
      if (side_r[DIV_LAT-1][l].zd || side_r[DIV_LAT-1][l].zg) begin
        res.gain[l] = GAIN_SAT;
        res.fault   = 1'b1;
      end else begin
        res.gain[l] = qg[l];
      end
    end
  end
endmodule
`default_nettype wire
